// ===== rtl/kch_pkg.sv =====
// ----------------------------------------------------------------------------
// kch_pkg
// shared constants, action codes and control bundles for the k-mer counter
// ----------------------------------------------------------------------------
package kch_pkg;

    localparam int KMER_LEN_DEF = 8;

    localparam int COUNT_W      = 8;
    localparam int BIN_NUM      = 256;
    localparam int BIN_W        = 8;
    localparam int KMER_CODE_W  = 16;
    localparam int BIN_COUNT_W  = 17;
    localparam int DIST_W       = 17;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
    localparam logic [BIN_W-1:0]   BIN_LAST  = 8'd255;

    typedef enum logic {
        ACT_FEED     = 1'b0,
        ACT_READ_BIN = 1'b1
    } action_t;

    // read request into the cumulative histogram memory
    typedef struct packed {
        logic             en;
        logic [BIN_W-1:0] addr_a;
        logic             lo_full;   // lower bound is bin 0: every k-mer
        logic [BIN_W-1:0] addr_b;
        logic             hi_empty;  // upper bound is past the last bin
    } hist_rd_t;

    // write request into the cumulative histogram memory
    typedef struct packed {
        logic             en;
        logic [BIN_W-1:0] addr;
    } hist_wr_t;

endpackage

// ===== rtl/kch_hist.sv =====
// ----------------------------------------------------------------------------
// kch_hist
// cumulative occurrence histogram: entry c holds the number of k-mers whose
// count is at least c, two registered read ports, one write port
// ----------------------------------------------------------------------------
module kch_hist
    import kch_pkg::*;
#(
    parameter int KMER_LEN = KMER_LEN_DEF,
    localparam int CNT_W   = 2 * KMER_LEN + 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  hist_rd_t         rd,
    input  hist_wr_t         wr,
    input  logic [CNT_W-1:0] wr_data,
    output logic [CNT_W-1:0] lo_val,
    output logic [CNT_W-1:0] hi_val
);

    localparam logic [CNT_W-1:0] TABLE_FULL = CNT_W'(1) << (2 * KMER_LEN);

    logic [CNT_W-1:0] mem [BIN_NUM];
    logic [CNT_W-1:0] rdat_a_reg;
    logic [CNT_W-1:0] rdat_b_reg;

    hist_rd_t         rd_q_reg;
    logic             lw_valid_reg;
    logic [BIN_W-1:0] lw_addr_reg;
    logic [CNT_W-1:0] lw_data_reg;

    logic             fwd_a;
    logic             fwd_b;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr_data;
        end
        if (rd.en)
        begin
            rdat_a_reg <= mem[rd.addr_a];
            rdat_b_reg <= mem[rd.addr_b];
        end
    end

    // last write covers a write landing on the same edge as the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_q_reg     <= '0;
            lw_valid_reg <= 1'b0;
            lw_addr_reg  <= '0;
            lw_data_reg  <= '0;
        end
        else
        begin
            if (rd.en)
            begin
                rd_q_reg <= rd;
            end
            if (wr.en)
            begin
                lw_valid_reg <= 1'b1;
                lw_addr_reg  <= wr.addr;
                lw_data_reg  <= wr_data;
            end
        end
    end

    assign fwd_a = lw_valid_reg && (lw_addr_reg == rd_q_reg.addr_a);
    assign fwd_b = lw_valid_reg && (lw_addr_reg == rd_q_reg.addr_b);

    always_comb
    begin
        if (rd_q_reg.lo_full)
            lo_val = TABLE_FULL;
        else if (fwd_a)
            lo_val = lw_data_reg;
        else
            lo_val = rdat_a_reg;

        if (rd_q_reg.hi_empty)
            hi_val = '0;
        else if (fwd_b)
            hi_val = lw_data_reg;
        else
            hi_val = rdat_b_reg;
    end

endmodule

// ===== rtl/kmer_count_histogram.sv =====
// ----------------------------------------------------------------------------
// kmer_count_histogram
// k-mer counter with saturating 8-bit counts and a 256-bin occurrence
// histogram over a stream of 2-bit bases
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over max(4^KMER_LEN, 256) addresses
// (65536 at the default KMER_LEN of 8) with in_ready low, zeroing the count
// table and the histogram memory. From then on it takes one beat per cycle,
// feed or read-bin, unless out_ready holds back the results, and each beat
// returns exactly one result beat through stage 1, stage 2 and the output
// register. The rate rests on the count table's read-modify-write path: the
// count is read on the accept edge, incremented and written back as the beat
// leaves stage 1, and a same-entry hit from the beat just ahead is forwarded.
// The histogram is kept as cumulative counts (k-mers with count at least c),
// so each increment touches a single entry; a read-bin beat reads two
// neighbors and subtracts them.
// ----------------------------------------------------------------------------
module kmer_count_histogram
    import kch_pkg::*;
#(
    parameter int KMER_LEN = KMER_LEN_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // input beat
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   action,
    input  logic [1:0]             base,
    input  logic                   read_start,
    input  logic [BIN_W-1:0]       bin_index,

    // result beat
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   counted,
    output logic [KMER_CODE_W-1:0] kmer_code,
    output logic [COUNT_W-1:0]     new_count,
    output logic [BIN_COUNT_W-1:0] bin_count,
    output logic [DIST_W-1:0]      distinct_unsaturated
);

    localparam int TBL_AW     = 2 * KMER_LEN;
    localparam int TABLE_SIZE = 1 << TBL_AW;
    localparam int CNT_W      = TBL_AW + 1;
    localparam int LEN_W      = $clog2(KMER_LEN + 1);
    localparam int CLR_DEPTH  = (TABLE_SIZE > BIN_NUM) ? TABLE_SIZE : BIN_NUM;
    localparam int CLR_W      = $clog2(CLR_DEPTH);

    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(KMER_LEN);
    localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);

    // ------------------------------------------------------------------
    // clearing pass after reset
    // ------------------------------------------------------------------
    logic             clr_busy_reg;
    logic             clr_busy_next;
    logic [CLR_W-1:0] clr_addr_reg;
    logic [CLR_W-1:0] clr_addr_next;
    logic             clr_ct_we;
    logic             clr_hist_we;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + CLR_W'(1);
            if (clr_addr_reg == CLR_LAST)
                clr_busy_next = 1'b0;
        end
    end

    assign clr_ct_we   = clr_busy_reg && (32'(clr_addr_reg) < TABLE_SIZE);
    assign clr_hist_we = clr_busy_reg && (32'(clr_addr_reg) < BIN_NUM);

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic s1_adv;
    logic s2_adv;
    logic in_fire;

    assign s2_adv   = s2_valid_reg && (!out_valid_reg || out_ready);
    assign s1_adv   = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign in_ready = !clr_busy_reg && (!s1_valid_reg || s1_adv);
    assign in_fire  = in_valid && in_ready;

    // ------------------------------------------------------------------
    // rolling k-mer, updated on every accepted feed beat
    // ------------------------------------------------------------------
    logic [TBL_AW-1:0] kmer_reg;
    logic [TBL_AW-1:0] kmer_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [TBL_AW+1:0] kmer_shift;
    logic              in_feed;
    logic              in_count;

    assign in_feed    = (action_t'(action) == ACT_FEED);
    assign kmer_shift = {kmer_reg, base};

    always_comb
    begin
        if (read_start)
        begin
            kmer_next = TBL_AW'(base);
            len_next  = LEN_W'(1);
        end
        else
        begin
            kmer_next = kmer_shift[TBL_AW-1:0];
            len_next  = (len_reg == LEN_FULL) ? len_reg : len_reg + LEN_W'(1);
        end
    end

    assign in_count = (len_next == LEN_FULL);

    // ------------------------------------------------------------------
    // stage 1: count table read data, saturating increment, write back
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] ct_mem [TABLE_SIZE];
    logic [COUNT_W-1:0] ct_rdata_reg;

    logic                ct_we;
    logic [TBL_AW-1:0]   ct_waddr;
    logic [COUNT_W-1:0]  ct_wdata;
    logic                ctlw_valid_reg;
    logic [TBL_AW-1:0]   ctlw_addr_reg;
    logic [COUNT_W-1:0]  ctlw_data_reg;

    logic                s1_feed_reg;
    logic                s1_count_reg;
    logic [TBL_AW-1:0]   s1_kmer_reg;
    logic [BIN_W-1:0]    s1_bin_reg;

    logic [COUNT_W-1:0]  s1_old;
    logic [COUNT_W-1:0]  s1_nv;
    logic                s1_inc;
    logic                s1_do_inc;

    logic [CNT_W-1:0]    unsat_reg;
    logic [CNT_W-1:0]    unsat_next;

    // the beat just ahead may have written this entry on our read edge
    assign s1_old    = (ctlw_valid_reg && (ctlw_addr_reg == s1_kmer_reg))
                       ? ctlw_data_reg : ct_rdata_reg;
    assign s1_inc    = (s1_old != COUNT_MAX);
    assign s1_nv     = s1_inc ? s1_old + COUNT_W'(1) : s1_old;
    assign s1_do_inc = s1_feed_reg && s1_count_reg && s1_inc;

    assign ct_we    = clr_ct_we || (s1_adv && s1_do_inc);
    assign ct_waddr = clr_busy_reg ? clr_addr_reg[TBL_AW-1:0] : s1_kmer_reg;
    assign ct_wdata = clr_busy_reg ? '0 : s1_nv;

    always_ff @(posedge clk)
    begin
        if (ct_we)
        begin
            ct_mem[ct_waddr] <= ct_wdata;
        end
        if (in_fire)
        begin
            ct_rdata_reg <= ct_mem[kmer_next];
        end
    end

    // number of k-mers with count 1..254
    always_comb
    begin
        unsat_next = unsat_reg;
        if (s1_adv && s1_do_inc)
        begin
            if (s1_old == '0)
                unsat_next = unsat_reg + CNT_W'(1);
            else if (s1_nv == COUNT_MAX)
                unsat_next = unsat_reg - CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // histogram memory, read on stage 1 exit, written on stage 2 exit
    // ------------------------------------------------------------------
    hist_rd_t         hist_rd;
    hist_wr_t         hist_wr;
    logic [CNT_W-1:0] hist_wdata;
    logic [CNT_W-1:0] hist_lo;
    logic [CNT_W-1:0] hist_hi;

    logic                s2_feed_reg;
    logic                s2_counted_reg;
    logic                s2_inc_reg;
    logic [TBL_AW-1:0]   s2_kmer_reg;
    logic [COUNT_W-1:0]  s2_nv_reg;
    logic [CNT_W-1:0]    s2_dist_reg;
    logic                s2_do_inc;

    // feed: entry nv to bump; read-bin: entries bin and bin + 1
    always_comb
    begin
        hist_rd.en       = s1_adv;
        hist_rd.addr_a   = s1_feed_reg ? s1_nv : s1_bin_reg;
        hist_rd.lo_full  = !s1_feed_reg && (s1_bin_reg == '0);
        hist_rd.addr_b   = s1_bin_reg + BIN_W'(1);
        hist_rd.hi_empty = (s1_bin_reg == BIN_LAST);
    end

    assign s2_do_inc = s2_feed_reg && s2_counted_reg && s2_inc_reg;

    always_comb
    begin
        hist_wr.en   = clr_hist_we || (s2_adv && s2_do_inc);
        hist_wr.addr = clr_busy_reg ? clr_addr_reg[BIN_W-1:0] : s2_nv_reg;
        hist_wdata   = clr_busy_reg ? '0 : hist_lo + CNT_W'(1);
    end

    kch_hist #(
        .KMER_LEN (KMER_LEN)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (hist_rd),
        .wr      (hist_wr),
        .wr_data (hist_wdata),
        .lo_val  (hist_lo),
        .hi_val  (hist_hi)
    );

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            kmer_reg       <= '0;
            len_reg        <= '0;
            unsat_reg      <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            ctlw_valid_reg <= 1'b0;
            ctlw_addr_reg  <= '0;
            ctlw_data_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            unsat_reg    <= unsat_next;

            if (in_fire && in_feed)
            begin
                kmer_reg <= kmer_next;
                len_reg  <= len_next;
            end

            if (ct_we)
            begin
                ctlw_valid_reg <= 1'b1;
                ctlw_addr_reg  <= ct_waddr;
                ctlw_data_reg  <= ct_wdata;
            end

            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                s2_valid_reg <= 1'b1;
            else if (s2_adv)
                s2_valid_reg <= 1'b0;

            if (s2_adv)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    logic                   counted_reg;
    logic [KMER_CODE_W-1:0] kmer_code_reg;
    logic [COUNT_W-1:0]     new_count_reg;
    logic [BIN_COUNT_W-1:0] bin_count_reg;
    logic [DIST_W-1:0]      dist_reg;
    logic [CNT_W-1:0]       bin_diff;

    assign bin_diff = hist_lo - hist_hi;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_feed_reg  <= in_feed;
            s1_count_reg <= in_count;
            s1_kmer_reg  <= kmer_next;
            s1_bin_reg   <= bin_index;
        end

        if (s1_adv)
        begin
            s2_feed_reg    <= s1_feed_reg;
            s2_counted_reg <= s1_feed_reg && s1_count_reg;
            s2_inc_reg     <= s1_inc;
            s2_kmer_reg    <= s1_kmer_reg;
            s2_nv_reg      <= s1_nv;
            s2_dist_reg    <= unsat_next;
        end

        if (s2_adv)
        begin
            counted_reg   <= s2_counted_reg;
            kmer_code_reg <= s2_counted_reg ? KMER_CODE_W'(s2_kmer_reg) : '0;
            new_count_reg <= s2_counted_reg ? s2_nv_reg : '0;
            bin_count_reg <= s2_feed_reg ? '0 : BIN_COUNT_W'(bin_diff);
            dist_reg      <= DIST_W'(s2_dist_reg);
        end
    end

    assign out_valid            = out_valid_reg;
    assign counted              = counted_reg;
    assign kmer_code            = kmer_code_reg;
    assign new_count            = new_count_reg;
    assign bin_count            = bin_count_reg;
    assign distinct_unsaturated = dist_reg;

endmodule

// ===== tb/sv/kmer_tally_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_tally_pkg
// k-mer tally predictor and result checker for the kmer_count_histogram bench
// ----------------------------------------------------------------------------
package kmer_tally_pkg;

    import kch_pkg::*;

    localparam int          KLEN       = KMER_LEN_DEF;
    localparam int unsigned TABLE_SIZE = 1 << (2 * KLEN);
    localparam int unsigned KMER_MASK  = TABLE_SIZE - 1;

    typedef struct packed {
        logic                   counted;
        logic [KMER_CODE_W-1:0] kmer_code;
        logic [COUNT_W-1:0]     new_count;
        logic [BIN_COUNT_W-1:0] bin_count;
        logic [DIST_W-1:0]      distinct_unsat;
    } tally_result_t;

    class kmer_tally_board;

        bit [COUNT_W-1:0] tally [TABLE_SIZE];
        int unsigned      occupancy [BIN_NUM];
        int unsigned      window;
        int unsigned      depth;
        int unsigned      unsat_kmers;
        tally_result_t    awaited_results [$];
        int               errors;

        function new();
            foreach (tally[i])
                tally[i] = '0;
            foreach (occupancy[i])
                occupancy[i] = 0;
            occupancy[0] = TABLE_SIZE;
            window       = 0;
            depth        = 0;
            unsat_kmers  = 0;
            errors       = 0;
        endfunction

        // advance the tally for one accepted input beat and queue its result
        function void note_beat(action_t act, logic [1:0] b, logic start,
                                logic [BIN_W-1:0] idx);
            tally_result_t r;
            int unsigned   old_c;
            int unsigned   new_c;
            r = '0;
            if (act == ACT_FEED)
            begin
                if (start)
                begin
                    window = 0;
                    depth  = 0;
                end
                window = ((window << 2) | b) & KMER_MASK;
                if (depth < KLEN)
                    depth++;
                if (depth >= KLEN)
                begin
                    old_c = tally[window];
                    new_c = old_c;
                    if (old_c < COUNT_MAX)
                    begin
                        new_c             = old_c + 1;
                        tally[window]     = new_c[COUNT_W-1:0];
                        occupancy[old_c] -= 1;
                        occupancy[new_c] += 1;
                        if (old_c == 0)
                            unsat_kmers++;
                        if (new_c == COUNT_MAX)
                            unsat_kmers--;
                    end
                    r.counted   = 1'b1;
                    r.kmer_code = window[KMER_CODE_W-1:0];
                    r.new_count = new_c[COUNT_W-1:0];
                end
            end
            else
            begin
                r.bin_count = occupancy[idx][BIN_COUNT_W-1:0];
            end
            r.distinct_unsat = unsat_kmers[DIST_W-1:0];
            awaited_results.push_back(r);
        endfunction

        function void diff(string field, logic [31:0] want, logic [31:0] seen);
            if (seen !== want)
            begin
                $error("%s: expected %0d, got %0d", field, want, seen);
                errors++;
            end
        endfunction

        function void check_beat(tally_result_t got);
            tally_result_t want;
            if (awaited_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            diff("counted", want.counted, got.counted);
            diff("kmer_code", want.kmer_code, got.kmer_code);
            diff("new_count", want.new_count, got.new_count);
            diff("bin_count", want.bin_count, got.bin_count);
            diff("distinct_unsaturated", want.distinct_unsat, got.distinct_unsat);
        endfunction

        function int waiting();
            return awaited_results.size();
        endfunction

        // flag anything still outstanding and hand back the error total
        function int wrap_up();
            if (awaited_results.size() != 0)
            begin
                $error("%0d expected results never arrived", awaited_results.size());
                errors++;
            end
            return errors;
        endfunction

    endclass

endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for kmer_count_histogram
// ----------------------------------------------------------------------------
// Feeds base and histogram-read beats through the valid/ready input channel,
// predicts every result beat with an independent k-mer tally and compares
// each field. Starts with a short directed sequence (reset contents, bases
// before any read start, a short read, extreme k-mer codes), then runs
// structured random reads: random, repetitive and recurring reads, short
// reads, reads missing their start flag, a long homopolymer run that drives
// a count into saturation, and histogram reads sprinkled throughout.
// ----------------------------------------------------------------------------
module tb;

    import kch_pkg::*;
    import kmer_tally_pkg::*;

    localparam int ITEMS_TOTAL = 1400;
    localparam int CALM_TAIL   = 150;   // no idling over the last beats
    localparam int STOCK_N     = 4;
    localparam int STOCK_LEN   = 30;
    localparam int HAMMER_LEN  = 300;   // enough repeats to saturate one k-mer
    localparam int PRESSURE_AT = 400;   // result beat that triggers the long stall
    localparam int PRESSURE_CY = 64;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    action_t                action;
    logic [1:0]             base;
    logic                   read_start;
    logic [BIN_W-1:0]       bin_index;
    logic                   out_valid;
    logic                   out_ready;
    logic                   counted;
    logic [KMER_CODE_W-1:0] kmer_code;
    logic [COUNT_W-1:0]     new_count;
    logic [BIN_COUNT_W-1:0] bin_count;
    logic [DIST_W-1:0]      distinct_unsaturated;

    kmer_tally_board board;

    // stimulus bookkeeping shared between the sender and the receiver
    int  beats_sent;
    int  results_seen;
    bit  calm;
    logic [1:0] stock [STOCK_N][STOCK_LEN];

    kmer_count_histogram dut
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .action               (action),
        .base                 (base),
        .read_start           (read_start),
        .bin_index            (bin_index),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .counted              (counted),
        .kmer_code            (kmer_code),
        .new_count            (new_count),
        .bin_count            (bin_count),
        .distinct_unsaturated (distinct_unsaturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop; covers the post-reset clearing pass with a wide margin
    initial
    begin
        #(10_000_000);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // present one beat and hold it until the block takes it; random idle
    // bursts only in two of every three 64-beat segments and never in the tail
    task automatic send_beat(action_t a, logic [1:0] b, logic s, logic [BIN_W-1:0] idx);
        int gap;
        if (!calm && ((beats_sent / 64) % 3 != 0) && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= a;
        base       <= b;
        read_start <= s;
        bin_index  <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_beat(a, b, s, idx);
        beats_sent++;
        calm = (beats_sent >= ITEMS_TOTAL - CALM_TAIL);
    endtask

    task automatic feed(logic [1:0] b, logic s);
        send_beat(ACT_FEED, b, s, BIN_W'($urandom));
    endtask

    task automatic read_bin(logic [BIN_W-1:0] idx);
        send_beat(ACT_READ_BIN, 2'($urandom), 1'($urandom), idx);
    endtask

    // bins near zero and near saturation are where the action is
    function automatic logic [BIN_W-1:0] pick_bin();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return BIN_W'($urandom_range(0, 8));
        else if (r == 5)
            return BIN_W'($urandom_range(250, 255));
        return BIN_W'($urandom);
    endfunction

    task automatic maybe_read_bin();
        if ($urandom_range(0, 7) == 0)
            read_bin(pick_bin());
    endtask

    // one random read: short, random, periodic or a recurring stock read;
    // some lack the start flag and a few carry a stray start mid-read
    task automatic random_read();
        int         kind;
        int         len;
        int         period;
        int         pick;
        logic [1:0] motif [4];
        logic [1:0] b;
        logic       first_start;
        kind        = $urandom_range(0, 9);
        period      = $urandom_range(1, 4);
        pick        = $urandom_range(0, STOCK_N - 1);
        first_start = ($urandom_range(0, 9) != 0);
        for (int j = 0; j < 4; j++)
            motif[j] = 2'($urandom_range(0, 3));
        if (kind == 0)
            len = $urandom_range(1, KLEN - 1);
        else if (kind <= 4)
            len = $urandom_range(KLEN, 40);
        else if (kind <= 7)
            len = $urandom_range(KLEN, 60);
        else
            len = STOCK_LEN;
        for (int i = 0; i < len; i++)
        begin
            if (kind <= 4)
                b = 2'($urandom_range(0, 3));
            else if (kind <= 7)
                b = motif[i % period];
            else
                b = stock[pick][i];
            maybe_read_bin();
            feed(b, (i == 0) ? first_start : ($urandom_range(0, 49) == 0));
        end
    endtask

    // long homopolymer: one k-mer climbs to 255 and then stays pinned
    task automatic hammer_run();
        logic [1:0] b;
        b = 2'($urandom_range(0, 3));
        for (int i = 0; i < HAMMER_LEN; i++)
        begin
            maybe_read_bin();
            feed(b, i == 0);
        end
        read_bin(BIN_LAST);
        read_bin(BIN_LAST - BIN_W'(1));
    endtask

    initial
    begin
        int reads_done;
        board      = new();
        beats_sent = 0;
        calm       = 1'b0;
        reads_done = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = ACT_FEED;
        base       = '0;
        read_start = 1'b0;
        bin_index  = '0;
        for (int p = 0; p < STOCK_N; p++)
            for (int i = 0; i < STOCK_LEN; i++)
                stock[p][i] = 2'($urandom_range(0, 3));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // histogram straight after reset: every k-mer sits in bin 0
        read_bin('0);
        read_bin(BIN_LAST);
        // bases before any read start continue the read begun at reset;
        // the k-th base completes the all-ones k-mer
        for (int i = 0; i < KLEN; i++)
            feed(2'd3, 1'b0);
        feed(2'd3, 1'b0);
        // short read: no counts
        feed(2'd1, 1'b1);
        feed(2'd2, 1'b0);
        feed(2'd0, 1'b0);
        // fresh read of zeros gives the all-zero k-mer
        feed(2'd0, 1'b1);
        for (int i = 1; i < KLEN; i++)
            feed(2'd0, 1'b0);
        read_bin(8'd1);
        read_bin(8'd2);
        read_bin('0);

        // --- random part ---
        while (beats_sent < ITEMS_TOTAL)
        begin
            if (reads_done == 3)
                hammer_run();
            random_read();
            reads_done++;
        end
        in_valid <= 1'b0;

        // drain, then give the pipeline time to show any stray beat
        while (board.waiting() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (board.wrap_up() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver side
    // ------------------------------------------------------------------

    // checks every result beat; stalls in random bursts, quiet whenever
    // (cyc / 128) % 3 is zero and in the tail, plus one long hold-off so the
    // block backs up and drops in_ready
    initial
    begin
        int            hold_left;
        int            cyc;
        bit            pressed;
        tally_result_t got;
        hold_left    = 0;
        cyc          = 0;
        pressed      = 1'b0;
        results_seen = 0;
        out_ready    = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (out_valid && out_ready)
            begin
                got.counted        = counted;
                got.kmer_code      = kmer_code;
                got.new_count      = new_count;
                got.bin_count      = bin_count;
                got.distinct_unsat = distinct_unsaturated;
                board.check_beat(got);
                results_seen++;
            end
            if (hold_left > 0)
                hold_left--;
            else if (!pressed && results_seen >= PRESSURE_AT)
            begin
                pressed   = 1'b1;
                hold_left = PRESSURE_CY;
            end
            else if (!calm && ((cyc / 128) % 3 != 0) && $urandom_range(0, 7) == 0)
                hold_left = $urandom_range(1, 6);
            out_ready <= (hold_left == 0);
        end
    end

endmodule
